// ----- hw/rtl/tbd_pkg.sv -----
package tbd_pkg;

  localparam int NumButtons = 3;
  localparam int TicksWidth = 10;
  localparam logic [TicksWidth-1:0] DebounceReset = 10'd50;
  localparam int HoldCountWidthDef = 16;
  localparam int ShownWidth = 16;

  typedef enum logic [1:0] {
    PRESS_NONE  = 2'd0,
    PRESS_GREEN = 2'd1,
    PRESS_RED   = 2'd2,
    PRESS_BLUE  = 2'd3
  } press_e;

  // per-button status handed from a lane to the top level
  typedef struct packed {
    logic stable_q;
    logic stable_d;
    logic rise;
  } lane_stat_t;

endpackage

// ----- hw/rtl/tbd_in_if.sv -----
interface tbd_in_if;
  logic valid;
  logic ready;
  logic raw_green;
  logic raw_red;
  logic raw_blue;

  modport source (output valid, output raw_green, output raw_red, output raw_blue,
                  input ready);
  modport sink (input valid, input raw_green, input raw_red, input raw_blue,
                output ready);
endinterface

// ----- hw/rtl/tbd_out_if.sv -----
interface tbd_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      press_event;
  logic                            stable_green;
  logic                            stable_red;
  logic                            stable_blue;
  logic                            combo_held;
  logic [tbd_pkg::ShownWidth-1:0]  combo_hold_ticks;

  modport source (output valid, output press_event, output stable_green,
                  output stable_red, output stable_blue, output combo_held,
                  output combo_hold_ticks, input ready);
  modport sink (input valid, input press_event, input stable_green,
                input stable_red, input stable_blue, input combo_held,
                input combo_hold_ticks, output ready);
endinterface

// ----- hw/rtl/tbd_cfg_if.sv -----
interface tbd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tbd_pkg::TicksWidth-1:0]  debounce_ticks;

  modport source (output valid, output debounce_ticks, input ready);
  modport sink (input valid, input debounce_ticks, output ready);
endinterface

// ----- hw/rtl/three_button_debouncer_with_hold_timer.sv -----
// Three-button debouncer with combo hold timer.
// in_i carries one item per millisecond tick with the raw green, red and blue
// levels. out_o returns one result per item: the press event (highest button
// wins when several rise together), the three debounced levels, the combo
// flag and the combo hold count in ticks, saturating.
// cfg_i writes the debounce time in ticks; it is always ready and is meant
// to be written while no item is in flight.
// An accepted item passes through the input register, then the result
// register, before its result shows on out_o.
// Throughput: one item per cycle while the receiver takes results; all per-button and combo updates are one
// pass of short logic between the input register and the result register.
// The input register keeps taking items while a result waits on out_o; when
// the receiver stalls with both registers full, in_i.ready drops.
// Reset: all buttons released, counters cleared, debounce time 50 ticks,
// no item held.
module three_button_debouncer_with_hold_timer #(
  parameter int HoldCountWidth = tbd_pkg::HoldCountWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tbd_in_if.sink       in_i,
  tbd_out_if.source    out_o,
  tbd_cfg_if.sink      cfg_i
);

  localparam int NB = tbd_pkg::NumButtons;

  logic [tbd_pkg::TicksWidth-1:0] deb_q;
  logic                           s1_valid_q;
  logic [NB-1:0]                  s1_raw_q;
  logic                           adv;
  tbd_pkg::lane_stat_t            stat [NB];
  logic [NB-1:0]                  stab_q, stab_d, rise;
  tbd_pkg::press_e                ev;
  logic [tbd_pkg::ShownWidth-1:0] shown;

  logic                           out_valid_q;
  logic [1:0]                     out_ev_q;
  logic [NB-1:0]                  out_stab_q;
  logic                           out_held_q;
  logic [tbd_pkg::ShownWidth-1:0] out_ticks_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= tbd_pkg::DebounceReset;
    end else if (cfg_i.valid) begin
      deb_q <= cfg_i.debounce_ticks;
    end
  end

  // advance the held item into the result register when it is free
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_raw_q <= {in_i.raw_blue, in_i.raw_red, in_i.raw_green};
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_lane
    tbd_lane u_lane (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .en_i             (adv),
      .raw_i            (s1_raw_q[b]),
      .debounce_ticks_i (deb_q),
      .stat_o           (stat[b])
    );
    assign stab_q[b] = stat[b].stable_q;
    assign stab_d[b] = stat[b].stable_d;
    assign rise[b]   = stat[b].rise;
  end

  always_comb begin
    if (rise[2]) begin
      ev = tbd_pkg::PRESS_BLUE;
    end else if (rise[1]) begin
      ev = tbd_pkg::PRESS_RED;
    end else if (rise[0]) begin
      ev = tbd_pkg::PRESS_GREEN;
    end else begin
      ev = tbd_pkg::PRESS_NONE;
    end
  end

  tbd_combo #(
    .HoldCountWidth (HoldCountWidth)
  ) u_combo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .was_held_i (&stab_q),
    .held_i     (&stab_d),
    .shown_o    (shown)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ev_q    <= ev;
      out_stab_q  <= stab_d;
      out_held_q  <= &stab_d;
      out_ticks_q <= shown;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.press_event      = out_ev_q;
  assign out_o.stable_green     = out_stab_q[0];
  assign out_o.stable_red       = out_stab_q[1];
  assign out_o.stable_blue      = out_stab_q[2];
  assign out_o.combo_held       = out_held_q;
  assign out_o.combo_hold_ticks = out_ticks_q;

endmodule

// ----- hw/rtl/tbd_lane.sv -----
module tbd_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            raw_i,
  input  logic [tbd_pkg::TicksWidth-1:0]  debounce_ticks_i,
  output tbd_pkg::lane_stat_t             stat_o
);

  logic                            last_q, last_d;
  logic                            stable_q, stable_d;
  logic [tbd_pkg::TicksWidth-1:0]  cnt_q, cnt_d;
  logic                            follow;

  always_comb begin
    last_d = raw_i;
    if (raw_i != last_q) begin
      cnt_d = '0;
    end else if (cnt_q != '1) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
    // test against the updated count, so a zero debounce follows at once
    follow   = (cnt_d >= debounce_ticks_i) && (raw_i != stable_q);
    stable_d = follow ? raw_i : stable_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b0;
      stable_q <= 1'b0;
      cnt_q    <= '0;
    end else if (en_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      cnt_q    <= cnt_d;
    end
  end

  assign stat_o.stable_q = stable_q;
  assign stat_o.stable_d = stable_d;
  assign stat_o.rise     = follow & raw_i;

endmodule

// ----- hw/rtl/tbd_combo.sv -----
module tbd_combo #(
  parameter int HoldCountWidth = tbd_pkg::HoldCountWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            was_held_i,
  input  logic                            held_i,
  output logic [tbd_pkg::ShownWidth-1:0]  shown_o
);

  logic [HoldCountWidth-1:0] cnt_q, cnt_d;

  always_comb begin
    if (!held_i || !was_held_i) begin
      cnt_d = '0;
    end else if (cnt_q != '1) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

  // clamp a wide count to the shown width
  if (HoldCountWidth > tbd_pkg::ShownWidth) begin : g_wide
    assign shown_o = (|cnt_d[HoldCountWidth-1:tbd_pkg::ShownWidth]) ? '1
                     : cnt_d[tbd_pkg::ShownWidth-1:0];
  end else begin : g_narrow
    assign shown_o = tbd_pkg::ShownWidth'(cnt_d);
  end

endmodule

// ----- dv/button_debounce_checker.sv -----
`timescale 1ns / 1ps
module button_debounce_checker #(
  parameter int HoldW = tbd_pkg::HoldCountWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tbd_in_if    tick_mon,
  tbd_out_if   res_mon,
  tbd_cfg_if   cfg_mon,
  output int   errors_o,
  output int   pending_o,
  output int   results_o,
  output int   presses_o,
  output int   max_hold_o
);

  localparam int ShownW = tbd_pkg::ShownWidth;

  typedef struct packed {
    tbd_pkg::press_e   press;
    logic              green;
    logic              red;
    logic              blue;
    logic              held;
    logic [ShownW-1:0] hold_ticks;
  } tick_result_t;

  localparam tbd_pkg::press_e BtnPress [tbd_pkg::NumButtons] =
    '{tbd_pkg::PRESS_GREEN, tbd_pkg::PRESS_RED, tbd_pkg::PRESS_BLUE};

  logic [tbd_pkg::TicksWidth-1:0] debounce_q;
  logic [tbd_pkg::NumButtons-1:0] raw_last;
  logic [tbd_pkg::TicksWidth-1:0] since_change [tbd_pkg::NumButtons];
  logic [tbd_pkg::NumButtons-1:0] level;
  logic [HoldW-1:0]               hold_cnt;
  tick_result_t                   expected_q [$];
  int                             err_cnt;
  int                             result_cnt;
  int                             press_cnt;
  int                             hold_max;

  // Advance the button state by one tick and return what the block must show.
  function automatic tick_result_t predict_tick(input logic [tbd_pkg::NumButtons-1:0] raw);
    tick_result_t r;
    logic         was_held;
    was_held = &level;
    r = '0;
    r.press = tbd_pkg::PRESS_NONE;
    for (int b = 0; b < tbd_pkg::NumButtons; b++) begin
      if (raw[b] != raw_last[b]) begin
        raw_last[b] = raw[b];
        since_change[b] = '0;
      end else if (since_change[b] != '1) begin
        since_change[b] = since_change[b] + 1'b1;
      end
      if (since_change[b] >= debounce_q && raw[b] != level[b]) begin
        level[b] = raw[b];
        // later buttons overwrite, so the highest one wins
        if (raw[b]) r.press = BtnPress[b];
      end
    end
    if (!(&level) || !was_held) begin
      hold_cnt = '0;
    end else if (hold_cnt != '1) begin
      hold_cnt = hold_cnt + 1'b1;
    end
    r.green = level[0];
    r.red   = level[1];
    r.blue  = level[2];
    r.held  = &level;
    if (!r.held) begin
      r.hold_ticks = '0;
    end else if (64'(hold_cnt) > 64'(16'hFFFF)) begin
      r.hold_ticks = '1;
    end else begin
      r.hold_ticks = ShownW'(hold_cnt);
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
               $time, result_cnt, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    if (!rst_ni) begin
      debounce_q = tbd_pkg::DebounceReset;
      raw_last   = '0;
      level      = '0;
      hold_cnt   = '0;
      for (int b = 0; b < tbd_pkg::NumButtons; b++) since_change[b] = '0;
      expected_q.delete();
      err_cnt    = 0;
      result_cnt = 0;
      press_cnt  = 0;
      hold_max   = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) debounce_q = cfg_mon.debounce_ticks;
      // retire the oldest result before queueing the new item
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result %0d arrived with nothing expected, actual press=%0d",
                   $time, result_cnt, res_mon.press_event);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          check_field("press_event", int'(want.press), int'(res_mon.press_event));
          check_field("stable_green", int'(want.green), int'(res_mon.stable_green));
          check_field("stable_red", int'(want.red), int'(res_mon.stable_red));
          check_field("stable_blue", int'(want.blue), int'(res_mon.stable_blue));
          check_field("combo_held", int'(want.held), int'(res_mon.combo_held));
          check_field("combo_hold_ticks", int'(want.hold_ticks),
                      int'(res_mon.combo_hold_ticks));
        end
        if (res_mon.press_event != tbd_pkg::PRESS_NONE) press_cnt++;
        if (int'(res_mon.combo_hold_ticks) > hold_max) begin
          hold_max = int'(res_mon.combo_hold_ticks);
        end
        result_cnt++;
      end
      if (tick_mon.valid && tick_mon.ready) begin
        expected_q.push_back(predict_tick({tick_mon.raw_blue, tick_mon.raw_red,
                                           tick_mon.raw_green}));
      end
    end
    errors_o   <= err_cnt;
    pending_o  <= expected_q.size();
    results_o  <= result_cnt;
    presses_o  <= press_cnt;
    max_hold_o <= hold_max;
  end

endmodule

// ----- dv/tb_three_button_debouncer_with_hold_timer.sv -----
`timescale 1ns / 1ps
module tb_three_button_debouncer_with_hold_timer;

  // raw levels as {blue, red, green}
  localparam logic [2:0] DirZero [19] = '{
    3'b000, 3'b001, 3'b001, 3'b000, 3'b010, 3'b000, 3'b100, 3'b000, 3'b011, 3'b000,
    3'b111, 3'b111, 3'b111, 3'b110, 3'b111, 3'b111, 3'b000, 3'b101, 3'b000
  };
  localparam logic [2:0] DirOne [6] = '{
    3'b001, 3'b001, 3'b000, 3'b001, 3'b000, 3'b000
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          chk_errors;
  int          chk_pending;
  int          chk_results;
  int          chk_presses;
  int          chk_hold_max;
  int unsigned items_sent;
  int unsigned settings_seen;
  int unsigned deb_now;
  bit          src_idle;
  bit          snk_idle;
  bit          long_stall_req;

  tbd_in_if  tick_if ();
  tbd_out_if res_if ();
  tbd_cfg_if cfg_if ();

  three_button_debouncer_with_hold_timer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  button_debounce_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_mon   (tick_if),
    .res_mon    (res_if),
    .cfg_mon    (cfg_if),
    .errors_o   (chk_errors),
    .pending_o  (chk_pending),
    .results_o  (chk_results),
    .presses_o  (chk_presses),
    .max_hold_o (chk_hold_max)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_tick(input logic [2:0] raw);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    tick_if.valid     <= 1'b1;
    tick_if.raw_green <= raw[0];
    tick_if.raw_red   <= raw[1];
    tick_if.raw_blue  <= raw[2];
    do @(posedge clk_i); while (!tick_if.ready);
    items_sent++;
  endtask

  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (chk_pending != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    // let the two pipeline stages settle
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_debounce(input logic [tbd_pkg::TicksWidth-1:0] value);
    drain_results();
    cfg_if.valid          <= 1'b1;
    cfg_if.debounce_ticks <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    deb_now = value;
    settings_seen++;
  endtask

  // Bounce toward a target pattern, then hold it for about the debounce time:
  // one tick short of it up to a few past, sometimes long enough for a combo.
  task automatic run_bursts(input int unsigned budget);
    int unsigned start;
    int unsigned len;
    int unsigned mode;
    logic [2:0]  target;
    start = items_sent;
    while (items_sent - start < budget) begin
      target = 3'($urandom_range(0, 7));
      mode   = $urandom_range(0, 9);
      if (mode < 8) begin
        repeat ($urandom_range(0, 4)) send_tick(target ^ 3'($urandom_range(1, 7)));
        len = deb_now + $urandom_range(0, 4);
        if (mode == 7) len += $urandom_range(5, 40);
        repeat (len) send_tick(target);
      end else begin
        repeat ($urandom_range(1, 6)) send_tick(3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left = 60;
      end else if (stall_left == 0 && snk_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_three_button_debouncer_with_hold_timer: errors");
    $finish;
  end

  initial begin : stimulus
    rst_ni                <= 1'b0;
    tick_if.valid         <= 1'b0;
    tick_if.raw_green     <= 1'b0;
    tick_if.raw_red       <= 1'b0;
    tick_if.raw_blue      <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.debounce_ticks <= '0;
    items_sent    = 0;
    settings_seen = 1;
    deb_now       = tbd_pkg::DebounceReset;
    src_idle      = 1'b1;
    snk_idle      = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single, paired and triple presses, releases and combo restart
    write_debounce(10'd0);
    foreach (DirZero[i]) send_tick(DirZero[i]);
    write_debounce(10'd1);
    foreach (DirOne[i]) send_tick(DirOne[i]);

    // bursts sized for the debounce time from reset; the block keeps the last written one
    drain_results();
    deb_now = tbd_pkg::DebounceReset;
    run_bursts(200);

    write_debounce(10'd0);
    run_bursts(120);
    write_debounce(10'd1);
    src_idle = 1'b0;
    run_bursts(100);
    src_idle = 1'b1;
    write_debounce(10'd2);
    run_bursts(60);
    // hold the receiver off so the block backs up into its input
    long_stall_req = 1'b1;
    run_bursts(80);
    write_debounce(10'd3);
    run_bursts(60);
    drain_results();
    run_bursts(60);
    write_debounce(10'($urandom_range(4, 12)));
    snk_idle = 1'b0;
    run_bursts(100);
    snk_idle = 1'b1;

    // longest debounce time; short holds never settle
    write_debounce(10'd1023);
    repeat (30) send_tick(3'b111);
    repeat (30) send_tick(3'b000);

    // no idling from here on: hold the combo for a long stretch
    src_idle = 1'b0;
    snk_idle = 1'b0;
    write_debounce(10'd0);
    repeat (40) send_tick(3'b111);
    write_debounce(10'd5);
    run_bursts(100);

    drain_results();
    if (chk_pending != 0) begin
      $display("%0t: %0d expected results never arrived", $time, chk_pending);
    end
    $display("Covered %0d ticks, %0d results checked, %0d debounce settings from 0 to 1023.",
             items_sent, chk_results, settings_seen);
    $display("Saw %0d debounced presses; longest combo hold shown was %0d ticks.",
             chk_presses, chk_hold_max);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("tb_three_button_debouncer_with_hold_timer: clean");
    end else begin
      $display("tb_three_button_debouncer_with_hold_timer: errors");
    end
    $finish;
  end

endmodule
